### hw/rtl/olist_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the ordered list engine
package olist_pkg;

  localparam int unsigned OLE_CAPACITY = 64;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned TOTAL_W      = 7;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_DEL_HEAD = 3'd2,
    REQ_DEL_TAIL = 3'd3,
    REQ_INS_POS  = 3'd4,
    REQ_DEL_VAL  = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_INVALID   = 3'd3,
    STAT_OOB       = 3'd4,
    STAT_FULL      = 3'd5
  } stat_e;

  typedef struct packed {
    logic [2:0]                req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [TOTAL_W-1:0]        entry_total;
    logic signed [VALUE_W-1:0] first_value;
    logic signed [VALUE_W-1:0] last_value;
  } rsp_t;

endpackage

### hw/rtl/ordered_list_engine.sv
`timescale 1ns / 1ps
// ordered list engine: packed list in one ram, walked one entry per cycle
//
//   channel | direction | payload | handshake
//   in      | input     | req_t   | in_valid_i / in_ready_o
//   out     | output    | rsp_t   | out_valid_o / out_ready_i
//
// inserts that move entries walk the ram read port down from the tail, deletes of the
// head or by value walk it up, one entry a cycle; each request then reads head and
// tail, and no new beat is taken until its result is registered. reset clears the
// count and control state but not the ram; an empty list reports zero head and tail.
// a stalled result waits in the output register while the next beat is taken in.
module ordered_list_engine import olist_pkg::*; #(
  parameter int unsigned CAPACITY = OLE_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_INS,
    ST_SCAN,
    ST_RD_HEAD,
    ST_RD_TAIL,
    ST_CAP_TAIL,
    ST_DONE
  } state_e;

  state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  stat_e   status_q, status_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic    issue_q, issue_d;
  logic    pend_q, pend_d;
  logic    found_q, found_d;
  logic    out_valid_q, out_valid_d;
  rsp_t    out_q, out_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [AW-1:0] where_q, where_d;
  logic [VALUE_W-1:0] head_q, head_d;
  logic [VALUE_W-1:0] tail_q, tail_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic          ins_go;
  logic [AW-1:0] ins_where;
  logic          is_empty;
  logic          is_full;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] cnt_low;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CapCnt);
  assign last_idx = AW'(count_q - CW'(1));
  assign cnt_low  = AW'(count_q);
  assign pos_ext  = PW'(in_data_i.position[6:0]);
  assign cnt_ext  = PW'(count_q);

  olist_ram #(
    .Width(VALUE_W),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    rd_ptr_d    = rd_ptr_q;
    rd_addr_d   = rd_ptr_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    val_d       = val_q;
    where_d     = where_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ram_we      = 1'b0;
    ram_waddr   = where_q;
    ram_wdata   = val_q;
    ram_re      = 1'b0;
    ram_raddr   = rd_ptr_q;
    ins_go      = 1'b0;
    ins_where   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d    = in_data_i.item_value;
          status_d = STAT_OK;
          state_d  = ST_RD_HEAD;
          case (req_e'(in_data_i.req_type))
            REQ_INS_HEAD: begin
              ins_go    = 1'b1;
              ins_where = '0;
            end
            REQ_INS_TAIL: begin
              ins_go    = 1'b1;
              ins_where = cnt_low;
            end
            REQ_DEL_HEAD: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else if (count_q == CW'(1)) begin
                count_d = '0;
              end else begin
                // pull every later entry down by one
                state_d  = ST_SCAN;
                rd_ptr_d = AW'(1);
                issue_d  = 1'b1;
                found_d  = 1'b1;
              end
            end
            REQ_DEL_TAIL: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            REQ_INS_POS: begin
              if (in_data_i.position[7]) begin
                status_d = STAT_INVALID;
              end else if (pos_ext > cnt_ext) begin
                status_d = STAT_OOB;
              end else begin
                ins_go    = 1'b1;
                ins_where = AW'(in_data_i.position[6:0]);
              end
            end
            REQ_DEL_VAL: begin
              if (is_empty) begin
                status_d = STAT_EMPTY;
              end else begin
                state_d  = ST_SCAN;
                rd_ptr_d = '0;
                issue_d  = 1'b1;
                found_d  = 1'b0;
              end
            end
            default: ;
          endcase
          if (ins_go) begin
            where_d = ins_where;
            if (is_full) begin
              status_d = STAT_FULL;
            end else if (ins_where == cnt_low) begin
              state_d = ST_INS;
            end else begin
              // move entries up, from the tail down to the insert slot
              state_d  = ST_SHIFT;
              rd_ptr_d = last_idx;
              issue_d  = 1'b1;
            end
          end
        end
      end
      ST_SHIFT: begin
        ram_re = issue_q;
        pend_d = issue_q;
        if (issue_q) begin
          if (rd_ptr_q == where_q) begin
            issue_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q - AW'(1);
          end
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q + AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue_q) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = where_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        state_d   = ST_RD_HEAD;
      end
      ST_SCAN: begin
        ram_re = issue_q;
        pend_d = issue_q;
        if (issue_q) begin
          if (rd_ptr_q == last_idx) begin
            issue_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + AW'(1);
          end
        end
        // once the victim is found, each later entry moves down one slot
        if (pend_q) begin
          if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_q - AW'(1);
            ram_wdata = ram_rdata;
          end else if (ram_rdata == val_q) begin
            found_d = 1'b1;
          end
        end
        if (!issue_q) begin
          state_d = ST_RD_HEAD;
          if (found_d) begin
            count_d  = count_q - CW'(1);
            status_d = STAT_OK;
          end else begin
            status_d = STAT_NOT_FOUND;
          end
        end
      end
      ST_RD_HEAD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = ST_RD_TAIL;
      end
      ST_RD_TAIL: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx;
        head_d    = ram_rdata;
        state_d   = ST_CAP_TAIL;
      end
      ST_CAP_TAIL: begin
        tail_d  = ram_rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = status_q;
          out_d.entry_total = TOTAL_W'(count_q);
          out_d.first_value = is_empty ? '0 : head_q;
          out_d.last_value  = is_empty ? '0 : tail_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      status_q    <= STAT_OK;
      rd_ptr_q    <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      status_q    <= status_d;
      rd_ptr_q    <= rd_ptr_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    val_q     <= val_d;
    where_q   <= where_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !ram_we)
    else $error("ram write while idle");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == CW'($past(count_q) + CW'(1)) ||
       count_q == CW'($past(count_q) - CW'(1))))
    else $error("entry count moved by more than one");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != ST_IDLE)
    else $error("accepted beat did not start work");

endmodule

### hw/rtl/olist_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module olist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the ordered list engine with a queue-based list predictor
module tb;
  import olist_pkg::*;

  localparam int          CAP            = OLE_CAPACITY;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = OLE_CAPACITY + 16;
  localparam logic [2:0]  REQ_SPARE_LO   = 3'd6;
  localparam logic [2:0]  REQ_SPARE_HI   = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  // predictor state: the list contents, head first
  logic signed [31:0] list_shadow[$];
  rsp_t               pending_rsp[$];
  rsp_t               want;
  bit                 steady_mode = 1'b0;
  int                 fail_count = 0;
  int                 req_sent = 0;
  int                 rsp_checked = 0;
  int                 depth_peak = 0;
  int                 idle_cycles = 0;
  int                 status_hits[6];

  ordered_list_engine i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  // apply one request to the shadow list and build the result it should give
  function automatic rsp_t apply_request(req_t r);
    rsp_t  res;
    stat_e st;
    int    n;
    int    idx;
    bit    found;
    n = list_shadow.size();
    st = STAT_OK;
    case (r.req_type)
      REQ_INS_HEAD: begin
        if (n >= CAP) st = STAT_FULL;
        else list_shadow.push_front(r.item_value);
      end
      REQ_INS_TAIL: begin
        if (n >= CAP) st = STAT_FULL;
        else list_shadow.push_back(r.item_value);
      end
      REQ_DEL_HEAD: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(list_shadow.pop_front());
      end
      REQ_DEL_TAIL: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(list_shadow.pop_back());
      end
      REQ_INS_POS: begin
        // invalid beats out of bounds, which beats full
        if (r.position < 0) st = STAT_INVALID;
        else if (int'(r.position) > n) st = STAT_OOB;
        else if (n >= CAP) st = STAT_FULL;
        else list_shadow.insert(int'(r.position), r.item_value);
      end
      REQ_DEL_VAL: begin
        if (n == 0) begin
          st = STAT_EMPTY;
        end else begin
          st = STAT_NOT_FOUND;
          found = 1'b0;
          for (idx = 0; idx < n && !found; idx++) begin
            if (list_shadow[idx] == r.item_value) begin
              list_shadow.delete(idx);
              found = 1'b1;
              st = STAT_OK;
            end
          end
        end
      end
      default: ;
    endcase
    res.status      = st;
    res.entry_total = TOTAL_W'(list_shadow.size());
    res.first_value = (list_shadow.size() == 0) ? '0 : list_shadow[0];
    res.last_value  = (list_shadow.size() == 0) ? '0 : list_shadow[list_shadow.size()-1];
    if (list_shadow.size() > depth_peak) depth_peak = list_shadow.size();
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pool_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic signed [31:0] insert_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 80 || list_shadow.size() == 0) return pool_value();
    return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
  endfunction

  function automatic logic signed [31:0] search_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && list_shadow.size() != 0)
      return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
    if (r < 85) return pool_value();
    return $urandom;
  endfunction

  function automatic logic signed [7:0] insert_position();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = list_shadow.size();
    if (r < 70) return 8'($urandom_range(0, n));
    if (r < 80) return 8'(n);
    if (r < 88) return 8'($urandom_range(128, 255));
    if (r < 95 && n < 127) return 8'($urandom_range(n + 1, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  // drive one beat and hold it until taken, then predict its result
  task automatic send_request(input logic [2:0] kind, input logic signed [31:0] value,
                              input logic signed [7:0] where);
    int gap;
    in_data  = '{req_type: kind, item_value: value, position: where};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(apply_request(in_data));
    req_sent++;
    @(negedge clk);
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_results_drained();
    // the last beat was already taken, so nothing may stay offered meanwhile
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int grow_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      send_request(($urandom_range(0, 1) != 0) ? REQ_SPARE_LO : REQ_SPARE_HI, $urandom,
                   8'($urandom));
    else if (r < 2 + grow_pct) begin
      case ($urandom_range(0, 2))
        0: send_request(REQ_INS_HEAD, insert_value(), 8'($urandom));
        1: send_request(REQ_INS_TAIL, insert_value(), 8'($urandom));
        default: send_request(REQ_INS_POS, insert_value(), insert_position());
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: send_request(REQ_DEL_HEAD, $urandom, 8'($urandom));
        1: send_request(REQ_DEL_TAIL, $urandom, 8'($urandom));
        default: send_request(REQ_DEL_VAL, search_value(), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_directed();
    send_request(REQ_DEL_HEAD, 32'sd1, 8'sd0);
    send_request(REQ_DEL_TAIL, 32'sd1, 8'sd0);
    send_request(REQ_DEL_VAL, 32'sd5, 8'sd0);
    send_request(REQ_INS_POS, 32'sd3, 8'sd1);
    send_request(REQ_INS_POS, 32'sd3, -8'sd128);
    send_request(REQ_INS_POS, VAL_MIN, 8'sd0);
    send_request(REQ_INS_HEAD, VAL_MAX, 8'sd127);
    send_request(REQ_INS_TAIL, 32'sd0, -8'sd1);
    send_request(REQ_INS_TAIL, -32'sd1, 8'sd0);
    send_request(REQ_INS_POS, 32'sd7, 8'sd4);
    send_request(REQ_INS_POS, 32'sd9, 8'sd2);
    send_request(REQ_INS_POS, 32'sd3, 8'sd127);
    send_request(REQ_INS_POS, 32'sd3, -8'sd1);
    send_request(REQ_INS_TAIL, 32'sd7, 8'sd0);
    send_request(REQ_DEL_VAL, 32'sd7, 8'sd0);
    send_request(REQ_DEL_VAL, 32'sd12345, 8'sd0);
    send_request(REQ_SPARE_LO, 32'sd1, 8'sd0);
    send_request(REQ_SPARE_HI, VAL_MIN, -8'sd128);
    send_request(REQ_DEL_VAL, VAL_MAX, 8'sd0);
    send_request(REQ_DEL_HEAD, 32'sd0, 8'sd0);
    send_request(REQ_DEL_TAIL, 32'sd0, 8'sd0);
    send_request(REQ_DEL_VAL, -32'sd1, 8'sd0);
    send_request(REQ_DEL_TAIL, 32'sd0, 8'sd0);
    send_request(REQ_DEL_HEAD, 32'sd0, 8'sd0);
  endtask

  task automatic test_fill_and_drain();
    // sender holds off until the engine has answered everything
    wait_results_drained();
    while (list_shadow.size() < CAP) begin
      case ($urandom_range(0, 2))
        0: send_request(REQ_INS_HEAD, insert_value(), 8'($urandom));
        1: send_request(REQ_INS_TAIL, insert_value(), 8'($urandom));
        default: send_request(REQ_INS_POS, insert_value(), 8'($urandom_range(0, list_shadow.size())));
      endcase
    end
    send_request(REQ_INS_HEAD, VAL_MAX, 8'sd0);
    send_request(REQ_INS_TAIL, VAL_MIN, 8'sd0);
    send_request(REQ_INS_POS, 32'sd1, 8'(CAP));
    send_request(REQ_INS_POS, 32'sd1, 8'sd0);
    send_request(REQ_INS_POS, 32'sd1, -8'sd1);
    send_request(REQ_INS_POS, 32'sd1, 8'(CAP + 1));
    send_request(REQ_DEL_VAL, list_shadow[CAP-1], 8'sd0);
    send_request(REQ_DEL_VAL, list_shadow[0], 8'sd0);
    while (list_shadow.size() > 0) begin
      case ($urandom_range(0, 2))
        0: send_request(REQ_DEL_HEAD, $urandom, 8'($urandom));
        1: send_request(REQ_DEL_TAIL, $urandom, 8'($urandom));
        default: send_request(REQ_DEL_VAL, search_value(), 8'($urandom));
      endcase
    end
    send_request(REQ_DEL_VAL, VAL_MIN, 8'sd0);
  endtask

  task automatic test_random_mix(input int count);
    int k;
    int grow;
    grow = 70;
    for (k = 0; k < count; k++) begin
      // swing between growing and shrinking so the list walks its whole range
      if (k % 120 == 0) grow = (grow > 50) ? 28 : 70;
      send_random(grow);
    end
  endtask

  task automatic test_back_to_back(input int count);
    int k;
    wait_results_drained();
    steady_mode = 1'b1;
    for (k = 0; k < count; k++) send_random(50);
    steady_mode = 1'b0;
  endtask

  // result sink: ready pattern in runs, short stalls mostly
  initial begin
    int  hold;
    bit  take;
    hold = 0;
    forever begin
      @(negedge clk);
      if (steady_mode) begin
        out_ready = 1'b1;
      end else begin
        if (hold == 0) begin
          take = ($urandom_range(0, 99) < 65);
          if (take) hold = $urandom_range(1, 8);
          else if ($urandom_range(0, 99) < 85) hold = $urandom_range(1, 3);
          else hold = $urandom_range(10, 40);
          out_ready = take;
        end
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        rsp_checked++;
        if (want.status < 6) status_hits[want.status]++;
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.entry_total !== want.entry_total) begin
          $error("entry_total: expected %0d, got %0d", want.entry_total, out_data.entry_total);
          fail_count++;
        end
        if (out_data.first_value !== want.first_value) begin
          $error("first_value: expected %0d, got %0d", want.first_value, out_data.first_value);
          fail_count++;
        end
        if (out_data.last_value !== want.last_value) begin
          $error("last_value: expected %0d, got %0d", want.last_value, out_data.last_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    foreach (status_hits[s]) status_hits[s] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mix(640);
    test_back_to_back(150);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests, %0d results checked, peak list depth %0d of %0d",
             req_sent, rsp_checked, depth_peak, CAP);
    $display("outcomes: ok %0d, empty %0d, not found %0d, invalid %0d, out of bounds %0d, full %0d",
             status_hits[STAT_OK], status_hits[STAT_EMPTY], status_hits[STAT_NOT_FOUND],
             status_hits[STAT_INVALID], status_hits[STAT_OOB], status_hits[STAT_FULL]);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/olist_pkg.sv
hw/rtl/olist_ram.sv
hw/rtl/ordered_list_engine.sv
test/tb.sv
